FILE: design/category_id_pair_tokenizer_assert.svh
// Assertion macros for the category id pair tokenizer.
`ifndef CATEGORY_ID_PAIR_TOKENIZER_ASSERT_SVH
`define CATEGORY_ID_PAIR_TOKENIZER_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define CIPT_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tokenizer assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define CIPT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tokenizer assertion failed");

`endif

FILE: design/cipt_pkg.sv
// Types, character codes and helper functions of the category id pair tokenizer.
package cipt_pkg;

	localparam int MAX_LEN_DEF = 256;

	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CH_UA   = 8'h41;
	localparam logic [7:0] CH_UZ   = 8'h5A;
	localparam logic [7:0] CH_LA   = 8'h61;
	localparam logic [7:0] CH_LZ   = 8'h7A;
	localparam logic [7:0] CH_A    = 8'h41;
	localparam logic [7:0] CH_C    = 8'h43;
	localparam logic [7:0] CH_D    = 8'h44;
	localparam logic [7:0] CH_Y    = 8'h59;
	localparam logic [7:0] CH_O    = 8'h4F;
	localparam logic [7:0] CH_K    = 8'h4B;
	localparam logic [7:0] CH_X    = 8'h58;
	localparam logic [7:0] CH_M    = 8'h4D;

	localparam logic [2:0] CAT_A    = 3'd0;
	localparam logic [2:0] CAT_C    = 3'd1;
	localparam logic [2:0] CAT_D    = 3'd2;
	localparam logic [2:0] CAT_Y    = 3'd3;
	localparam logic [2:0] CAT_O    = 3'd4;
	localparam logic [2:0] CAT_K    = 3'd5;
	localparam logic [2:0] CAT_X    = 3'd6;
	localparam logic [2:0] CAT_NONE = 3'd7;

	localparam logic [15:0] ID_MAX   = 16'hFFFF;
	localparam logic [7:0]  PAIR_MAX = 8'hFF;

	typedef enum logic [1:0] {
		PH_START,
		PH_CAT,
		PH_ID
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_MARKOV,
		ST_BAD
	} status_t;

	typedef struct packed {
		logic [7:0] ch;
	} char_t;

	typedef struct packed {
		logic        pair_valid;
		logic [2:0]  category;
		logic [15:0] id_value;
		logic        done_res;
		status_t     status;
		logic [7:0]  pair_count;
	} token_t;

	function automatic logic is_letter(input logic [7:0] c);
		is_letter = (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		is_digit = (c >= CH_0 && c <= CH_9);
	endfunction

	function automatic logic [2:0] code_of(input logic [7:0] c);
		case (c)
			CH_A:    code_of = CAT_A;
			CH_C:    code_of = CAT_C;
			CH_D:    code_of = CAT_D;
			CH_Y:    code_of = CAT_Y;
			CH_O:    code_of = CAT_O;
			CH_K:    code_of = CAT_K;
			CH_X:    code_of = CAT_X;
			default: code_of = CAT_NONE;
		endcase
	endfunction

endpackage

FILE: design/cipt_stream_if.sv
// Valid/ready stream interface used for the character and token channels.
interface cipt_stream_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/category_id_pair_tokenizer.sv
// A character is taken into the input register, and its token then into the token register.
// Throughput: one character per cycle while the token side does not stall; the per-character
// state update sits between the input register and the token register.
// Back pressure on the token side stalls the input register, which stalls the input.
// Reset (arst_n low, asynchronous): both registers empty, parser in its start state,
// no error, pair and character counts cleared.
`include "category_id_pair_tokenizer_assert.svh"

module category_id_pair_tokenizer #(
	parameter int MAX_LEN = cipt_pkg::MAX_LEN_DEF
) (
	input logic           clk,
	input logic           arst_n,
	cipt_stream_if.sink   chars,
	cipt_stream_if.source tokens
);

	localparam int CntW = $clog2(MAX_LEN + 2);
	localparam logic [CntW-1:0] LenMax = CntW'(MAX_LEN);

	// Input register
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       advance;

	// Parser state
	cipt_pkg::phase_t  phase_q, phase_d;
	logic [2:0]        cat_code_q, cat_code_d;
	logic [1:0]        cat_letters_q, cat_letters_d;
	logic [7:0]        first_letter_q, first_letter_d;
	logic [15:0]       id_acc_q, id_acc_d;
	cipt_pkg::status_t err_q, err_d;
	logic [7:0]        pairs_q, pairs_d;
	logic [CntW-1:0]   char_cnt_q, char_cnt_d;

	// Token register
	logic              res_fire;
	cipt_pkg::token_t  res;
	logic              out_valid_q;
	cipt_pkg::token_t  out_q;

	logic [19:0] id_next;
	logic [2:0]  code;
	logic        lone_m;

	assign advance      = valid_s1 && (!out_valid_q || tokens.ready);
	assign chars.ready  = !valid_s1 || advance;
	assign tokens.valid = out_valid_q;
	assign tokens.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.valid && chars.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			ch_s1 <= chars.data.ch;
		end
	end

	assign id_next = {1'b0, id_acc_q, 3'b000} + {3'b000, id_acc_q, 1'b0}
		+ {12'd0, ch_s1 - cipt_pkg::CH_0};
	assign code    = cipt_pkg::code_of(first_letter_q);
	assign lone_m  = (cat_letters_q == 2'd1) && (first_letter_q == cipt_pkg::CH_M);

	always_comb begin
		phase_d        = phase_q;
		cat_code_d     = cat_code_q;
		cat_letters_d  = cat_letters_q;
		first_letter_d = first_letter_q;
		id_acc_d       = id_acc_q;
		err_d          = err_q;
		pairs_d        = pairs_q;
		char_cnt_d     = char_cnt_q;
		res_fire       = 1'b0;
		res            = '0;

		if (ch_s1 == cipt_pkg::CH_NUL) begin
			res_fire     = 1'b1;
			res.done_res = 1'b1;
			if (err_q == cipt_pkg::ST_OK && phase_q == cipt_pkg::PH_ID) begin
				res.pair_valid = 1'b1;
				res.category   = cat_code_q;
				res.id_value   = id_acc_q;
				res.status     = cipt_pkg::ST_OK;
				res.pair_count = (pairs_q == cipt_pkg::PAIR_MAX) ? pairs_q : pairs_q + 8'd1;
			end else begin
				res.pair_count = pairs_q;
				if (err_q != cipt_pkg::ST_OK) begin
					res.status = err_q;
				end else if (phase_q == cipt_pkg::PH_CAT && lone_m) begin
					res.status = cipt_pkg::ST_MARKOV;
				end else begin
					res.status = cipt_pkg::ST_BAD;
				end
			end
			// The terminator returns the parser to its reset state.
			phase_d        = cipt_pkg::PH_START;
			cat_code_d     = '0;
			cat_letters_d  = '0;
			first_letter_d = '0;
			id_acc_d       = '0;
			err_d          = cipt_pkg::ST_OK;
			pairs_d        = '0;
			char_cnt_d     = '0;
		end else begin
			if (char_cnt_q <= LenMax) begin
				char_cnt_d = char_cnt_q + CntW'(1);
			end
			if (char_cnt_d > LenMax && err_q == cipt_pkg::ST_OK) begin
				err_d = cipt_pkg::ST_BAD;
			end
			if (err_d == cipt_pkg::ST_OK) begin
				if (phase_q == cipt_pkg::PH_ID) begin
					if (cipt_pkg::is_digit(ch_s1)) begin
						id_acc_d = (id_next > 20'(cipt_pkg::ID_MAX)) ? cipt_pkg::ID_MAX
							: id_next[15:0];
					end else if (cipt_pkg::is_letter(ch_s1)) begin
						res_fire       = 1'b1;
						res.pair_valid = 1'b1;
						res.category   = cat_code_q;
						res.id_value   = id_acc_q;
						if (pairs_q != cipt_pkg::PAIR_MAX) begin
							pairs_d = pairs_q + 8'd1;
						end
						first_letter_d = ch_s1;
						cat_letters_d  = 2'd1;
						phase_d        = cipt_pkg::PH_CAT;
					end else begin
						err_d = cipt_pkg::ST_BAD;
					end
				end else if (cipt_pkg::is_letter(ch_s1)) begin
					if (phase_q == cipt_pkg::PH_START) begin
						first_letter_d = ch_s1;
						cat_letters_d  = 2'd1;
						phase_d        = cipt_pkg::PH_CAT;
					end else if (cat_letters_q < 2'd2) begin
						cat_letters_d = cat_letters_q + 2'd1;
					end
				end else if (cipt_pkg::is_digit(ch_s1)) begin
					if (phase_q != cipt_pkg::PH_CAT) begin
						err_d = cipt_pkg::ST_BAD;
					end else if (lone_m) begin
						err_d = cipt_pkg::ST_MARKOV;
					end else if (cat_letters_q != 2'd1 || code == cipt_pkg::CAT_NONE) begin
						err_d = cipt_pkg::ST_BAD;
					end else begin
						cat_code_d = code;
						id_acc_d   = {8'd0, ch_s1 - cipt_pkg::CH_0};
						phase_d    = cipt_pkg::PH_ID;
					end
				end else begin
					err_d = cipt_pkg::ST_BAD;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= cipt_pkg::PH_START;
			cat_code_q     <= '0;
			cat_letters_q  <= '0;
			first_letter_q <= '0;
			id_acc_q       <= '0;
			err_q          <= cipt_pkg::ST_OK;
			pairs_q        <= '0;
			char_cnt_q     <= '0;
		end else if (advance) begin
			phase_q        <= phase_d;
			cat_code_q     <= cat_code_d;
			cat_letters_q  <= cat_letters_d;
			first_letter_q <= first_letter_d;
			id_acc_q       <= id_acc_d;
			err_q          <= err_d;
			pairs_q        <= pairs_d;
			char_cnt_q     <= char_cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_fire;
		end else if (tokens.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_fire) begin
			out_q <= res;
		end
	end

	// A beat without a pair is only ever the end-of-string beat.
	`CIPT_ASSERT_IMPL(a_empty_is_done, out_valid_q && !out_q.pair_valid, out_q.done_res)
	// Status and count stay zero on beats before the terminator.
	`CIPT_ASSERT_IMPL(a_mid_clean, out_valid_q && !out_q.done_res,
		out_q.status == cipt_pkg::ST_OK && out_q.pair_count == 8'd0)
	// A pair always carries a category from the set.
	`CIPT_ASSERT_IMPL(a_cat_legal, out_valid_q && out_q.pair_valid,
		out_q.category != cipt_pkg::CAT_NONE)
	// The terminator leaves the parser in its start state.
	`CIPT_ASSERT_NEXT(a_term_clears, advance && ch_s1 == cipt_pkg::CH_NUL,
		phase_q == cipt_pkg::PH_START && err_q == cipt_pkg::ST_OK && pairs_q == 8'd0)
	// Once set, an error holds until the terminator.
	`CIPT_ASSERT_NEXT(a_err_sticky,
		err_q != cipt_pkg::ST_OK && !(advance && ch_s1 == cipt_pkg::CH_NUL),
		err_q == $past(err_q))

endmodule
